// ===== rtl/core/ffcsa_pkg.sv =====
// Shared types and constants of the first-fit contiguous slot allocator.
package ffcsa_pkg;

   localparam int FIELD_W  = 11;
   localparam int ROW_BITS = 8;
   localparam int ROW_SH   = 3;

   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   localparam logic ST_OK      = 1'b0;
   localparam logic ST_NO_ROOM = 1'b1;

   typedef struct packed {
      logic load;
      logic read;
      logic eval;
      logic write;
   } ffcsa_cmd_type;

   typedef struct packed {
      logic is_release;
      logic alloc_zero;
      logic rel_empty;
      logic found;
      logic last_row;
      logic paint_last;
   } ffcsa_stat_type;

endpackage

// ===== rtl/core/ffcsa_datapath.sv =====
// Datapath: slot bitmap memory, run scanner, range painter and result registers.
module ffcsa_datapath import ffcsa_pkg::*; #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [FIELD_W-1:0]  csr_wdata,
   input  logic                req_type,
   input  logic [FIELD_W-1:0]  req_start_slot,
   input  logic [FIELD_W-1:0]  req_run_length,
   input  ffcsa_cmd_type       cmd,
   output ffcsa_stat_type      stat,
   output logic                rsp_status,
   output logic [FIELD_W-1:0]  rsp_granted_start
);

   localparam int ROW_COUNT   = (MAX_SLOTS + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_W       = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int SLOT_W      = $clog2(MAX_SLOTS + 1);
   localparam int WW          = ((SLOT_W > FIELD_W) ? SLOT_W : FIELD_W) + 1;
   localparam int RESET_COUNT = (MAX_SLOTS < 1024) ? MAX_SLOTS : 1024;

   // A set bit marks a used slot; bit b of row r is slot 8r+b+1.
   logic [ROW_BITS-1:0] row_mem [ROW_COUNT];
   logic [ROW_COUNT-1:0] valid_ff;
   logic [ROW_BITS-1:0] rd_row_ff;
   logic                rd_valid_ff;

   logic [WW-1:0]    count_ff, count_in;
   logic [ROW_W-1:0] row_ff;
   logic [WW-1:0]    len_ff, run_ff, run_start_ff, lo_ff, hi_ff, granted_ff;
   logic             used_ff, status_ff;

   logic [ROW_BITS-1:0] row_eff, wr_row;
   logic [WW-1:0]       base;
   logic [WW-1:0]       ev_run, ev_start, ev_first;
   logic                ev_found;
   logic [WW-1:0]       rq_start, rq_len, rel_lo, rel_hi;
   logic [WW-1:0]       wdata_ext;

   function automatic logic [ROW_W-1:0] row_of(input logic [WW-1:0] slot);
      logic [WW-1:0] t;
      t = slot - WW'(1);
      return t[ROW_W+ROW_SH-1:ROW_SH];
   endfunction

   assign rq_start  = WW'(req_start_slot);
   assign rq_len    = WW'(req_run_length);
   assign wdata_ext = WW'(csr_wdata);

   always_comb begin
      if (wdata_ext == '0) begin
         count_in = WW'(1);
      end else if (wdata_ext > WW'(MAX_SLOTS)) begin
         count_in = WW'(MAX_SLOTS);
      end else begin
         count_in = wdata_ext;
      end
   end

   always_comb begin
      rel_lo = (rq_start == '0) ? WW'(1) : rq_start;
      rel_hi = rq_start + rq_len - WW'(1);
      if (rel_hi > count_ff) begin
         rel_hi = count_ff;
      end
   end

   assign row_eff = rd_valid_ff ? rd_row_ff : '0;
   assign base    = WW'({row_ff, {ROW_SH{1'b0}}});

   // Run search over the eight slots of one row, carrying the run across rows.
   always_comb begin
      logic [WW-1:0] slot;
      logic          free;
      ev_run   = run_ff;
      ev_start = run_start_ff;
      ev_found = 1'b0;
      ev_first = '0;
      for (int b = 0; b < ROW_BITS; b++) begin
         slot = base + WW'(b + 1);
         free = (slot <= count_ff) && !row_eff[b];
         if (!ev_found) begin
            if (free) begin
               if (ev_run == '0) begin
                  ev_start = slot;
               end
               ev_run = ev_run + WW'(1);
               if (ev_run == len_ff) begin
                  ev_found = 1'b1;
                  ev_first = ev_start;
               end
            end else begin
               ev_run = '0;
            end
         end
      end
   end

   always_comb begin
      logic [WW-1:0] slot;
      wr_row = row_eff;
      for (int b = 0; b < ROW_BITS; b++) begin
         slot = base + WW'(b + 1);
         if (slot >= lo_ff && slot <= hi_ff) begin
            wr_row[b] = used_ff;
         end
      end
   end

   always_comb begin
      stat.is_release = (req_type == REQ_RELEASE);
      stat.alloc_zero = (rq_len == '0);
      stat.rel_empty  = (rq_len == '0) || (rel_lo > rel_hi);
      stat.found      = ev_found;
      stat.last_row   = (row_ff == row_of(count_ff));
      stat.paint_last = (row_ff == row_of(hi_ff));
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         row_mem[row_ff] <= wr_row;
      end
      if (cmd.read) begin
         rd_row_ff <= row_mem[row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         count_ff    <= WW'(RESET_COUNT);
      end else begin
         if (csr_we) begin
            valid_ff <= '0;
            count_ff <= count_in;
         end else if (cmd.write) begin
            valid_ff[row_ff] <= 1'b1;
         end
         if (cmd.read) begin
            rd_valid_ff <= valid_ff[row_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         len_ff       <= rq_len;
         run_ff       <= '0;
         run_start_ff <= '0;
         granted_ff   <= '0;
         status_ff    <= (req_type == REQ_ALLOC && rq_len == '0) ? ST_NO_ROOM : ST_OK;
         if (req_type == REQ_RELEASE) begin
            lo_ff   <= rel_lo;
            hi_ff   <= rel_hi;
            used_ff <= 1'b0;
            row_ff  <= row_of(rel_lo);
         end else begin
            row_ff <= '0;
         end
      end else if (cmd.eval) begin
         run_ff       <= ev_run;
         run_start_ff <= ev_start;
         if (ev_found) begin
            lo_ff      <= ev_first;
            hi_ff      <= ev_first + len_ff - WW'(1);
            used_ff    <= 1'b1;
            granted_ff <= ev_first;
            row_ff     <= row_of(ev_first);
         end else if (stat.last_row) begin
            status_ff <= ST_NO_ROOM;
         end else begin
            row_ff <= row_ff + ROW_W'(1);
         end
      end else if (cmd.write) begin
         row_ff <= row_ff + ROW_W'(1);
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_granted_start = granted_ff[FIELD_W-1:0];

endmodule

// ===== rtl/core/ffcsa_ctrl.sv =====
// Controller: sequences the row scan and the read-modify-write paint of each request.
module ffcsa_ctrl import ffcsa_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  ffcsa_stat_type stat,
   output ffcsa_cmd_type  cmd,
   output logic           busy,
   output logic           rsp_strobe
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_EV,
      S_PAINT_RD,
      S_PAINT_WR
   } state_type;

   state_type state_ff;
   logic      strobe_ff;

   always_comb begin
      cmd.load  = (state_ff == S_IDLE) && start;
      cmd.read  = (state_ff == S_SCAN_RD) || (state_ff == S_PAINT_RD);
      cmd.eval  = (state_ff == S_SCAN_EV);
      cmd.write = (state_ff == S_PAINT_WR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  if (stat.is_release) begin
                     if (stat.rel_empty) begin
                        strobe_ff <= 1'b1;
                     end else begin
                        state_ff <= S_PAINT_RD;
                     end
                  end else if (stat.alloc_zero) begin
                     strobe_ff <= 1'b1;
                  end else begin
                     state_ff <= S_SCAN_RD;
                  end
               end
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_EV;
            end
            S_SCAN_EV: begin
               if (stat.found) begin
                  state_ff <= S_PAINT_RD;
               end else if (stat.last_row) begin
                  state_ff  <= S_IDLE;
                  strobe_ff <= 1'b1;
               end else begin
                  state_ff <= S_SCAN_RD;
               end
            end
            S_PAINT_RD: begin
               state_ff <= S_PAINT_WR;
            end
            S_PAINT_WR: begin
               if (stat.paint_last) begin
                  state_ff  <= S_IDLE;
                  strobe_ff <= 1'b1;
               end else begin
                  state_ff <= S_PAINT_RD;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// ===== rtl/core/first_fit_contiguous_slot_allocator.sv =====
// Top level of the first-fit contiguous slot allocator.
//
//   channel  ports                                              transfer
//   request  start, busy, req_type, req_start_slot, req_run_length  start && !busy
//   result   rsp_strobe, rsp_status, rsp_granted_start           rsp_strobe
//   config   csr_we, csr_wdata                                   csr_we
//
// Slots live in a bitmap memory of eight slots per row. An allocate scans rows until
// the run completes or the last row is done, then paints the rows of the run; a
// release only paints rows. Each row costs one read and then one evaluation or
// write through the single memory port; a request with no slots to touch skips both.
// Reset and slot-count writes clear all row valid bits at once, so no sweep runs.
// The result is shown for one cycle; the receiver cannot stall it.
module first_fit_contiguous_slot_allocator import ffcsa_pkg::*; #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic [FIELD_W-1:0] req_start_slot,
   input  logic [FIELD_W-1:0] req_run_length,
   output logic               rsp_strobe,
   output logic               rsp_status,
   output logic [FIELD_W-1:0] rsp_granted_start,
   input  logic               csr_we,
   input  logic [FIELD_W-1:0] csr_wdata
);

   ffcsa_cmd_type  cmd;
   ffcsa_stat_type stat;

   ffcsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   ffcsa_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_type          (req_type),
      .req_start_slot    (req_start_slot),
      .req_run_length    (req_run_length),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_granted_start (rsp_granted_start)
   );

endmodule

// ===== rtl/core/ffcsa_checker.sv =====
// Port-level checks of the slot allocator and their binding to the top level.
module ffcsa_checker import ffcsa_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic               rsp_status,
   input logic [FIELD_W-1:0] rsp_granted_start
);

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // Zero-length requests answer in the next cycle, so strobes may follow one another.
   a_strobe_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) || $past(start)))
      else $error("result strobe without a request");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted request neither worked on nor answered");

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_strobe)
      else $error("request finished without a result");

   a_refusal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_NO_ROOM) |-> (rsp_granted_start == '0))
      else $error("refusal carries a start slot");

endmodule

bind first_fit_contiguous_slot_allocator ffcsa_checker u_ffcsa_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_status        (rsp_status),
   .rsp_granted_start (rsp_granted_start)
);

// ===== dv/first_fit_contiguous_slot_allocator_tb.sv =====
// Self-checking testbench of the first-fit contiguous slot allocator.
module first_fit_contiguous_slot_allocator_tb;
   import ffcsa_pkg::*;

   localparam int MAX_SLOTS  = 1024;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic               status;
      logic [FIELD_W-1:0] granted;
   } grant_type;

   // Tracks the free map as a flat bitmap and queues the grant each request should produce.
   class grant_tracker;
      bit        slot_free [1:MAX_SLOTS];
      int        slot_count;
      grant_type pending_grants [$];
      int        errors;

      function void rebuild(logic [FIELD_W-1:0] value);
         int n;
         n = value;
         if (n < 1) n = 1;
         if (n > MAX_SLOTS) n = MAX_SLOTS;
         slot_count = n;
         for (int i = 1; i <= MAX_SLOTS; i++) slot_free[i] = 1'b1;
      endfunction

      function void note_request(logic kind, logic [FIELD_W-1:0] first,
                                 logic [FIELD_W-1:0] length);
         grant_type g;
         int        run, lo, hi, len;
         g.status  = ST_OK;
         g.granted = '0;
         len = length;
         if (kind == REQ_ALLOC) begin
            g.status = ST_NO_ROOM;
            run = 0;
            if (len != 0) begin
               for (int i = 1; i <= slot_count; i++) begin
                  run = slot_free[i] ? run + 1 : 0;
                  if (run == len) begin
                     g.status  = ST_OK;
                     g.granted = FIELD_W'(i - len + 1);
                     for (int j = i - len + 1; j <= i; j++) slot_free[j] = 1'b0;
                     break;
                  end
               end
            end
         end else if (len != 0) begin
            lo = first;
            hi = lo + len - 1;
            if (lo < 1) lo = 1;
            if (hi > slot_count) hi = slot_count;
            for (int j = lo; j <= hi; j++) slot_free[j] = 1'b1;
         end
         pending_grants.push_back(g);
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_result(logic status, logic [FIELD_W-1:0] granted);
         grant_type g;
         if (pending_grants.size() == 0) begin
            report($sformatf("unexpected result status=%0d start=%0d", status, granted));
            return;
         end
         g = pending_grants.pop_front();
         if (status !== g.status)
            report($sformatf("status %0d, expected %0d", status, g.status));
         if (granted !== g.granted)
            report($sformatf("granted_start %0d, expected %0d", granted, g.granted));
      endtask

      function int pending();
         return pending_grants.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_type;
   logic [FIELD_W-1:0] req_start_slot;
   logic [FIELD_W-1:0] req_run_length;
   logic               rsp_strobe;
   logic               rsp_status;
   logic [FIELD_W-1:0] rsp_granted_start;
   logic               csr_we;
   logic [FIELD_W-1:0] csr_wdata;

   grant_tracker tracker;
   int           idle_cycles;

   first_fit_contiguous_slot_allocator #(.MAX_SLOTS(MAX_SLOTS)) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_start_slot    (req_start_slot),
      .req_run_length    (req_run_length),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_granted_start (rsp_granted_start),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) tracker.check_result(rsp_status, rsp_granted_start);
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("first_fit_contiguous_slot_allocator_tb failed");
            $finish;
         end
      end
   end

   task automatic send_request(logic kind, int first, int length);
      req_type       <= kind;
      req_start_slot <= FIELD_W'(first);
      req_run_length <= FIELD_W'(length);
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      tracker.note_request(kind, FIELD_W'(first), FIELD_W'(length));
   endtask

   task automatic random_gap();
      int pick, n;
      pick = $urandom_range(0, 99);
      n = (pick < 70) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // The block must be idle before the slot count changes, as the write frees every slot.
   task automatic write_slot_count(int value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= FIELD_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      tracker.rebuild(FIELD_W'(value));
      @(posedge clock);
   endtask

   task automatic random_phase(int items);
      logic kind;
      int   length, first, pick;
      for (int k = 0; k < items; k++) begin
         kind = ($urandom_range(0, 99) < 60) ? REQ_ALLOC : REQ_RELEASE;
         pick = $urandom_range(0, 99);
         if (pick < 80) length = $urandom_range(1, 24);
         else if (pick < 90) length = $urandom_range(0, 2047);
         else length = $urandom_range(0, tracker.slot_count);
         if ($urandom_range(0, 99) < 80) first = $urandom_range(1, tracker.slot_count);
         else first = $urandom_range(0, 2047);
         send_request(kind, first, length);
         random_gap();
         if (k == items / 2 && $urandom_range(0, 1)) drain();
      end
   endtask

   initial begin
      tracker        = new();
      tracker.rebuild(FIELD_W'(1024));
      reset          = 1'b1;
      start          = 1'b0;
      req_type       = REQ_ALLOC;
      req_start_slot = '0;
      req_run_length = '0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed edges at the reset slot count.
      send_request(REQ_ALLOC, 0, 0);
      send_request(REQ_ALLOC, 5, 1024);
      send_request(REQ_ALLOC, 0, 1);
      send_request(REQ_RELEASE, 0, 5);
      send_request(REQ_ALLOC, 2047, 4);
      send_request(REQ_ALLOC, 0, 1);
      send_request(REQ_RELEASE, 1020, 2047);
      send_request(REQ_RELEASE, 2047, 3);
      send_request(REQ_RELEASE, 1025, 1);
      send_request(REQ_RELEASE, 10, 0);
      send_request(REQ_ALLOC, 0, 2047);
      send_request(REQ_ALLOC, 0, 5);
      send_request(REQ_RELEASE, 1, 1024);
      send_request(REQ_ALLOC, 0, 1024);
      drain();
      write_slot_count(1);
      send_request(REQ_ALLOC, 0, 1);
      send_request(REQ_ALLOC, 0, 1);
      send_request(REQ_RELEASE, 1, 1);
      send_request(REQ_ALLOC, 0, 2);
      write_slot_count(0);
      send_request(REQ_ALLOC, 0, 1);
      write_slot_count(2047);
      send_request(REQ_ALLOC, 0, 1024);

      write_slot_count(1024);
      random_phase(100);
      write_slot_count(2);
      random_phase(60);
      write_slot_count($urandom_range(3, 1023));
      random_phase(100);
      write_slot_count($urandom_range(0, 2047));
      random_phase(90);
      write_slot_count(1024);
      random_phase(100);

      drain();
      repeat (600) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("first_fit_contiguous_slot_allocator_tb passed");
      end else begin
         $display("first_fit_contiguous_slot_allocator_tb failed");
      end
      $finish;
   end

endmodule
